[hw/rtl/grid_obstacle_inflation_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the grid obstacle inflation block
// Concurrent checks sampled on clk and switched off while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef GRID_OBSTACLE_INFLATION_MACROS_SVH
`define GRID_OBSTACLE_INFLATION_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define GOI_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define GOI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/goi_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// goi_pkg
// Shared constants, register indexes, types and the sequencer state enum.
// ---------------------------------------------------------------------------
package goi_pkg;

  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;

  localparam int COORD_W = 6;
  localparam int SIZE_W  = 7;
  localparam int RAD_W   = 3;
  localparam int COST_W  = 8;
  localparam int ADDR_W  = 2 * COORD_W;
  localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [RAD_W-1:0]  RADIUS_RST = 3'd4;
  localparam logic [SIZE_W-1:0] WIDTH_RST  = SIZE_W'(MAX_WIDTH);
  localparam logic [SIZE_W-1:0] HEIGHT_RST = SIZE_W'(MAX_HEIGHT);

  localparam logic [COST_W-1:0] INFLATED_COST = 8'd254;
  localparam logic [COST_W-1:0] FREE_COST     = 8'd0;

  // register indexes (word address bits of paddr)
  localparam logic [1:0] REG_RADIUS      = 2'd0;
  localparam logic [1:0] REG_GRID_WIDTH  = 2'd1;
  localparam logic [1:0] REG_GRID_HEIGHT = 2'd2;

  // action codes
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  typedef struct packed {
    logic [RAD_W-1:0]  radius;
    logic [SIZE_W-1:0] grid_width;
    logic [SIZE_W-1:0] grid_height;
  } cfg_t;

  typedef struct packed {
    logic               action;
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_y;
    logic [COST_W-1:0]  cost;
  } item_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [COST_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic              valid;
    logic [COST_W-1:0] value;
    logic              oob;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_SCAN,
    ST_DRAIN,
    ST_RESULT
  } state_t;

endpackage

[hw/rtl/goi_cfg_regs.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// goi_cfg_regs
// APB-style register file: radius, grid width and grid height.
// ---------------------------------------------------------------------------
module goi_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [goi_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [goi_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [goi_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready,
  output goi_pkg::cfg_t                    cfg
);

  logic [goi_pkg::RAD_W-1:0]  radius_r;
  logic [goi_pkg::SIZE_W-1:0] grid_width_r;
  logic [goi_pkg::SIZE_W-1:0] grid_height_r;
  logic                       wr_en;
  logic [1:0]                 reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r      <= goi_pkg::RADIUS_RST;
      grid_width_r  <= goi_pkg::WIDTH_RST;
      grid_height_r <= goi_pkg::HEIGHT_RST;
    end else if (wr_en) begin
      if (reg_idx == goi_pkg::REG_RADIUS) begin
        radius_r <= pwdata[goi_pkg::RAD_W-1:0];
      end
      if (reg_idx == goi_pkg::REG_GRID_WIDTH) begin
        grid_width_r <= pwdata[goi_pkg::SIZE_W-1:0];
      end
      if (reg_idx == goi_pkg::REG_GRID_HEIGHT) begin
        grid_height_r <= pwdata[goi_pkg::SIZE_W-1:0];
      end
    end
  end

  always_comb begin
    unique case (reg_idx)
      goi_pkg::REG_RADIUS:      prdata = goi_pkg::CFG_DATA_W'(radius_r);
      goi_pkg::REG_GRID_WIDTH:  prdata = goi_pkg::CFG_DATA_W'(grid_width_r);
      goi_pkg::REG_GRID_HEIGHT: prdata = goi_pkg::CFG_DATA_W'(grid_height_r);
      default:                  prdata = '0;
    endcase
  end

  assign cfg.radius      = radius_r;
  assign cfg.grid_width  = grid_width_r;
  assign cfg.grid_height = grid_height_r;

endmodule

[hw/rtl/goi_grid_mem.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// goi_grid_mem
// Cost grid storage: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module goi_grid_mem (
  input  logic                         clk,
  input  goi_pkg::mem_req_t            req,
  output logic [goi_pkg::COST_W-1:0]   rd_data
);

  logic [goi_pkg::COST_W-1:0] mem [goi_pkg::DEPTH];
  logic [goi_pkg::COST_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_data_r <= mem[req.raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[hw/rtl/goi_scan_ctrl.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// goi_scan_ctrl
// Sequencer: bounds check, cell write, and window scan through the memory.
// ---------------------------------------------------------------------------
module goi_scan_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  goi_pkg::cfg_t                cfg,
  input  logic                         item_valid,
  input  goi_pkg::item_t               item,
  output logic                         item_ready,
  output goi_pkg::mem_req_t            mem_req,
  input  logic [goi_pkg::COST_W-1:0]   rd_data,
  output goi_pkg::res_t                res,
  input  logic                         res_ready
);

  localparam int CW = goi_pkg::COORD_W;
  localparam int SW = goi_pkg::SIZE_W;

  goi_pkg::state_t state_r, state_nxt;
  goi_pkg::item_t  item_r, item_nxt;

  logic [CW-1:0]             sx_r, sx_nxt;
  logic [CW-1:0]             sy_r, sy_nxt;
  logic [CW-1:0]             xlo_r, xlo_nxt;
  logic [CW-1:0]             xhi_r, xhi_nxt;
  logic [CW-1:0]             yhi_r, yhi_nxt;
  logic                      rd_pend_r, rd_pend_nxt;
  logic [goi_pkg::COST_W-1:0] value_r, value_nxt;
  logic                      oob_r, oob_nxt;

  logic [SW-1:0] w_eff, h_eff, w_last, h_last;
  logic [SW-1:0] x_sum, y_sum;
  logic [CW-1:0] rad_ext;
  logic [CW-1:0] x_lo, y_lo, x_hi, y_hi;
  logic          oob;
  logic          hit;

  // clipped window bounds and bounds check for the held item
  always_comb begin
    w_eff   = (cfg.grid_width > SW'(goi_pkg::MAX_WIDTH)) ?
              SW'(goi_pkg::MAX_WIDTH) : cfg.grid_width;
    h_eff   = (cfg.grid_height > SW'(goi_pkg::MAX_HEIGHT)) ?
              SW'(goi_pkg::MAX_HEIGHT) : cfg.grid_height;
    oob     = ({1'b0, item_r.cell_x} >= w_eff) || ({1'b0, item_r.cell_y} >= h_eff);
    w_last  = w_eff - SW'(1);
    h_last  = h_eff - SW'(1);
    rad_ext = CW'(cfg.radius);
    x_lo    = (item_r.cell_x > rad_ext) ? item_r.cell_x - rad_ext : '0;
    y_lo    = (item_r.cell_y > rad_ext) ? item_r.cell_y - rad_ext : '0;
    x_sum   = {1'b0, item_r.cell_x} + {1'b0, rad_ext};
    y_sum   = {1'b0, item_r.cell_y} + {1'b0, rad_ext};
    x_hi    = (x_sum > w_last) ? w_last[CW-1:0] : x_sum[CW-1:0];
    y_hi    = (y_sum > h_last) ? h_last[CW-1:0] : y_sum[CW-1:0];
  end

  assign hit = rd_pend_r && (rd_data != goi_pkg::FREE_COST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= goi_pkg::ST_IDLE;
      rd_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_pend_r <= rd_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r  <= item_nxt;
    sx_r    <= sx_nxt;
    sy_r    <= sy_nxt;
    xlo_r   <= xlo_nxt;
    xhi_r   <= xhi_nxt;
    yhi_r   <= yhi_nxt;
    value_r <= value_nxt;
    oob_r   <= oob_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    sx_nxt        = sx_r;
    sy_nxt        = sy_r;
    xlo_nxt       = xlo_r;
    xhi_nxt       = xhi_r;
    yhi_nxt       = yhi_r;
    value_nxt     = value_r;
    oob_nxt       = oob_r;
    rd_pend_nxt   = 1'b0;
    item_ready    = 1'b0;
    mem_req.we    = 1'b0;
    mem_req.waddr = {item_r.cell_y, item_r.cell_x};
    mem_req.wdata = item_r.cost;
    mem_req.re    = 1'b0;
    mem_req.raddr = {sy_r, sx_r};
    res.valid     = 1'b0;
    res.value     = value_r;
    res.oob       = oob_r;

    unique case (state_r)
      goi_pkg::ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          item_nxt  = item;
          state_nxt = goi_pkg::ST_PREP;
        end
      end
      goi_pkg::ST_PREP: begin
        oob_nxt   = oob;
        value_nxt = goi_pkg::FREE_COST;
        if (oob || item_r.action == goi_pkg::ACT_WRITE) begin
          mem_req.we = !oob;
          state_nxt  = goi_pkg::ST_RESULT;
        end else begin
          sx_nxt    = x_lo;
          sy_nxt    = y_lo;
          xlo_nxt   = x_lo;
          xhi_nxt   = x_hi;
          yhi_nxt   = y_hi;
          state_nxt = goi_pkg::ST_SCAN;
        end
      end
      goi_pkg::ST_SCAN: begin
        if (hit) begin
          // stop at the first occupied cell; no further read is issued
          value_nxt = goi_pkg::INFLATED_COST;
          state_nxt = goi_pkg::ST_RESULT;
        end else begin
          mem_req.re  = 1'b1;
          rd_pend_nxt = 1'b1;
          if (sx_r == xhi_r) begin
            sx_nxt = xlo_r;
            if (sy_r == yhi_r) begin
              state_nxt = goi_pkg::ST_DRAIN;
            end else begin
              sy_nxt = sy_r + CW'(1);
            end
          end else begin
            sx_nxt = sx_r + CW'(1);
          end
        end
      end
      goi_pkg::ST_DRAIN: begin
        if (hit) begin
          value_nxt = goi_pkg::INFLATED_COST;
        end
        state_nxt = goi_pkg::ST_RESULT;
      end
      goi_pkg::ST_RESULT: begin
        res.valid = 1'b1;
        if (res_ready) begin
          state_nxt = goi_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = goi_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[hw/rtl/grid_obstacle_inflation.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// grid_obstacle_inflation
// Square-window obstacle inflation over a 64 x 64 byte cost grid.
// ---------------------------------------------------------------------------
// One transaction at a time. A write, or any transaction outside the grid,
// goes from acceptance through the prepare state to the result state. A read
// scans the clipped window row by row through the single read port of the
// grid memory, one cell per cycle, and stops at the first nonzero cell; the
// window holds at most (2*radius+1)^2 cells, so 81 for a full window at the
// reset radius of 4. The port is ready again once the result is loaded into
// the output register.
// The grid powers up undefined: write every cell before any read whose
// window covers it.
// ---------------------------------------------------------------------------
module grid_obstacle_inflation (
  input  logic                             clk,
  input  logic                             rst_n,
  // input stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [23:0]                      in_tdata,   // cell_x[5:0], cell_y[11:6],
                                                       // cost[19:12], zero[23:20]
  input  logic                             in_tuser,   // action
  // result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [7:0]                       out_tdata,  // inflated_value[7:0]
  output logic                             out_tuser,  // out_of_bounds
  // configuration
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [goi_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [goi_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [goi_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                             cfg_pready
);

  goi_pkg::cfg_t     cfg;
  goi_pkg::item_t    item;
  goi_pkg::mem_req_t mem_req;
  goi_pkg::res_t     res;
  logic [goi_pkg::COST_W-1:0] rd_data;
  logic                       res_ready;

  logic                       out_tvalid_r, out_tvalid_nxt;
  logic [goi_pkg::COST_W-1:0] out_tdata_r, out_tdata_nxt;
  logic                       out_tuser_r, out_tuser_nxt;

  assign item.action = in_tuser;
  assign item.cell_x = in_tdata[5:0];
  assign item.cell_y = in_tdata[11:6];
  assign item.cost   = in_tdata[19:12];

  goi_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  goi_grid_mem u_grid_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  goi_scan_ctrl u_scan_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (in_tvalid),
    .item       (item),
    .item_ready (in_tready),
    .mem_req    (mem_req),
    .rd_data    (rd_data),
    .res        (res),
    .res_ready  (res_ready)
  );

  // output register: load when empty or being drained
  assign res_ready = !out_tvalid_r || out_tready;

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    if (res.valid && res_ready) begin
      out_tvalid_nxt = 1'b1;
      out_tdata_nxt  = res.value;
      out_tuser_nxt  = res.oob;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

`include "grid_obstacle_inflation_macros.svh"

  `GOI_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready,
    "input accepted while a transaction is still in progress")
  `GOI_ASSERT_SAME(a_oob_no_value, out_tvalid && out_tuser, out_tdata == goi_pkg::FREE_COST,
    "out-of-bounds transaction returned a nonzero value")
  `GOI_ASSERT_SAME(a_value_legal, out_tvalid,
    out_tdata == goi_pkg::FREE_COST || out_tdata == goi_pkg::INFLATED_COST,
    "result value is neither free nor inflated")
  `GOI_ASSERT_SAME(a_no_write_on_read, mem_req.we, !mem_req.re,
    "grid written while a window scan is reading")

endmodule
